// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the CAN signal extract/insert block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
// Check that a condition never occurs at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== rtl/csei_pkg.sv =====
// Package with the types, constants and helper functions of the CAN signal extract/insert block.
`default_nettype none
package csei_pkg;

	// Field widths of the transaction payload.
	localparam int unsigned FRAME_W = 64;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned BIT_W   = 6;

	// Longest legal signal, in bits.
	localparam int unsigned MAX_LEN = 32;

	// The aligned frame carries one signal width of zero padding below or above it.
	localparam int unsigned PAD_W = VALUE_W;
	localparam int unsigned EXT_W = FRAME_W + PAD_W;
	localparam int unsigned POS_W = $clog2(EXT_W);

	// Command and byte order codes.
	localparam logic CMD_EXTRACT    = 1'b0;
	localparam logic CMD_INSERT     = 1'b1;
	localparam logic ORDER_INTEL    = 1'b0;
	localparam logic ORDER_MOTOROLA = 1'b1;

	localparam logic [VALUE_W-1:0] MASK_ALL = '1;

	// Payload of the first pipeline stage: decoded command and aligned frame.
	typedef struct packed {
		logic               cmd;
		logic               err;
		logic               sgn;
		logic               moto;
		logic [BIT_W-1:0]   len;
		logic [POS_W-1:0]   pos;
		logic [VALUE_W-1:0] mask;
		logic [VALUE_W-1:0] val;
		logic [EXT_W-1:0]   ext;
	} s1_t;

	// Payload of the second pipeline stage: shifted field, masks and aligned frame.
	typedef struct packed {
		logic               cmd;
		logic               err;
		logic               sgn;
		logic               moto;
		logic [BIT_W-1:0]   len;
		logic [VALUE_W-1:0] mask;
		logic [VALUE_W-1:0] extr;
		logic [EXT_W-1:0]   ext;
		logic [EXT_W-1:0]   ins_mask;
		logic [EXT_W-1:0]   ins_val;
	} s2_t;

	// Reverse the byte order of a frame. Motorola signals are contiguous in this view.
	function automatic logic [FRAME_W-1:0] byte_swap(input logic [FRAME_W-1:0] f);
		logic [FRAME_W-1:0] r;
		for (int i = 0; i < FRAME_W / 8; i++) begin
			r[8*i +: 8] = f[FRAME_W - 8 - 8*i +: 8];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/csei_align.sv =====
// First pipeline stage: length check, mask generation and frame alignment.
`default_nettype none
module csei_align
	import csei_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_vld,
	output logic                    in_rdy,
	input  wire logic               command,
	input  wire logic [FRAME_W-1:0] frame_in,
	input  wire logic [BIT_W-1:0]   start_bit,
	input  wire logic [BIT_W-1:0]   bit_length,
	input  wire logic               byte_order,
	input  wire logic               sign_mode,
	input  wire logic [VALUE_W-1:0] raw_value,
	output logic                    vld_s1,
	output s1_t                     data_s1,
	input  wire logic               nxt_rdy
);

	s1_t              nxt;
	logic [BIT_W-1:0] mask_sh;
	logic [BIT_W-1:0] moto_lin;

	// The stage takes a transaction when it is empty or its content moves on.
	assign in_rdy = !vld_s1 || nxt_rdy;

	// Decode the signal description and place the frame in the padded field.
	always_comb begin
		nxt.cmd  = command;
		nxt.sgn  = sign_mode;
		nxt.moto = byte_order;
		nxt.len  = bit_length;
		nxt.err  = (bit_length == '0) || (bit_length > BIT_W'(MAX_LEN));
		// A shift by the full width leaves an empty mask; that case is an error anyway.
		mask_sh  = BIT_W'(MAX_LEN) - bit_length;
		nxt.mask = MASK_ALL >> mask_sh;
		nxt.val  = raw_value & nxt.mask;
		// Motorola bit position counted upward from the MSB of byte 0.
		moto_lin = {start_bit[BIT_W-1:3], ~start_bit[2:0]};
		if (byte_order == ORDER_MOTOROLA) begin
			nxt.ext = {byte_swap(frame_in), {PAD_W{1'b0}}};
			nxt.pos = POS_W'(EXT_W) - POS_W'(moto_lin) - POS_W'(bit_length);
		end else begin
			nxt.ext = {{PAD_W{1'b0}}, frame_in};
			nxt.pos = POS_W'(start_bit);
		end
	end

	// Stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_rdy) begin
			vld_s1 <= in_vld;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (in_rdy && in_vld) begin
			data_s1 <= nxt;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/csei_shift.sv =====
// Second pipeline stage: shifts the field out of the frame and the insert masks into place.
`default_nettype none
module csei_shift
	import csei_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic vld_s1,
	output logic      rdy_s1,
	input  wire s1_t  data_s1,
	output logic      vld_s2,
	output s2_t       data_s2,
	input  wire logic nxt_rdy
);

	s2_t nxt;

	assign rdy_s1 = !vld_s2 || nxt_rdy;

	// Barrel shifts on the padded frame.
	always_comb begin
		nxt.cmd      = data_s1.cmd;
		nxt.err      = data_s1.err;
		nxt.sgn      = data_s1.sgn;
		nxt.moto     = data_s1.moto;
		nxt.len      = data_s1.len;
		nxt.mask     = data_s1.mask;
		nxt.ext      = data_s1.ext;
		nxt.extr     = VALUE_W'(data_s1.ext >> data_s1.pos) & data_s1.mask;
		nxt.ins_mask = EXT_W'(data_s1.mask) << data_s1.pos;
		nxt.ins_val  = EXT_W'(data_s1.val) << data_s1.pos;
	end

	// Stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s2 <= vld_s1;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (rdy_s1 && vld_s1) begin
			data_s2 <= nxt;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/csei_merge.sv =====
// Third pipeline stage: sign extension, frame merge and the output register.
`default_nettype none
module csei_merge
	import csei_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         vld_s2,
	output logic              rdy_s2,
	input  wire s2_t          data_s2,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [VALUE_W-1:0] signal_value,
	output logic [FRAME_W-1:0] frame_out,
	output logic              length_error
);

	localparam int unsigned IDX_W = $clog2(VALUE_W);

	logic [IDX_W-1:0]   msb_idx;
	logic [VALUE_W-1:0] value;
	logic [EXT_W-1:0]   merged;
	logic [FRAME_W-1:0] frame;
	logic               vld_s3;
	logic [VALUE_W-1:0] value_s3;
	logic [FRAME_W-1:0] frame_s3;
	logic               err_s3;

	assign rdy_s2 = !vld_s3 || !out_stall;

	// Extend the extracted field and write the insert field into the frame.
	always_comb begin
		msb_idx = IDX_W'(data_s2.len - BIT_W'(1));
		value   = data_s2.extr;
		if (data_s2.sgn && (data_s2.len < BIT_W'(MAX_LEN)) && data_s2.extr[msb_idx]) begin
			value = data_s2.extr | ~data_s2.mask;
		end
		if (data_s2.err || (data_s2.cmd == CMD_INSERT)) begin
			value = '0;
		end
		merged = data_s2.ext;
		if (!data_s2.err && (data_s2.cmd == CMD_INSERT)) begin
			merged = (data_s2.ext & ~data_s2.ins_mask) | data_s2.ins_val;
		end
		// Undo the alignment; bits pushed into the padding are dropped here.
		if (data_s2.moto == ORDER_MOTOROLA) begin
			frame = byte_swap(merged[EXT_W-1:PAD_W]);
		end else begin
			frame = merged[FRAME_W-1:0];
		end
	end

	// Output valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (rdy_s2) begin
			vld_s3 <= vld_s2;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s2) begin
			value_s3 <= value;
			frame_s3 <= frame;
			err_s3   <= data_s2.err;
		end
	end

	assign out_valid    = vld_s3;
	assign signal_value = value_s3;
	assign frame_out    = frame_s3;
	assign length_error = err_s3;

endmodule
`default_nettype wire

// ===== rtl/can_signal_extract_insert_core.sv =====
// Top level of the CAN signal extract/insert block.
//
// Each input transaction carries an 8-byte CAN payload and a signal description
// (start bit, length, Intel or Motorola byte order, signedness) and a command.
// Extract returns the signal value, sign- or zero-extended, with the frame unchanged.
// Insert writes the low bit_length bits of raw_value into the frame and returns it.
// A length of 0 or above 32 sets length_error, returns value 0 and the unchanged frame.
// Both channels use valid/stall; a transaction moves on an edge with valid high
// and stall low. Every input transaction gives exactly one output transaction.
// A transaction passes three registered stages from input acceptance to output valid:
// alignment, barrel shift, then merge into the output register.
// Throughput through the three-stage pipeline is one transaction per cycle while out_stall is low.
// While the receiver stalls, the output holds and the stages behind it fill;
// in_stall rises once all three stages hold a transaction.
// Reset clears all stage valid bits; the block accepts input in the first cycle
// after reset is released.
`default_nettype none
`include "assert_macros.svh"
module can_signal_extract_insert_core
	import csei_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               command,
	input  wire logic [FRAME_W-1:0] frame_in,
	input  wire logic [BIT_W-1:0]   start_bit,
	input  wire logic [BIT_W-1:0]   bit_length,
	input  wire logic               byte_order,
	input  wire logic               sign_mode,
	input  wire logic [VALUE_W-1:0] raw_value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [VALUE_W-1:0]      signal_value,
	output logic [FRAME_W-1:0]      frame_out,
	output logic                    length_error
);

	logic in_rdy;
	logic vld_s1;
	logic rdy_s1;
	logic vld_s2;
	logic rdy_s2;
	s1_t  data_s1;
	s2_t  data_s2;

	assign in_stall = !in_rdy;

	// Stage one: decode and align.
	csei_align u_align (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_vld     (in_valid),
		.in_rdy     (in_rdy),
		.command    (command),
		.frame_in   (frame_in),
		.start_bit  (start_bit),
		.bit_length (bit_length),
		.byte_order (byte_order),
		.sign_mode  (sign_mode),
		.raw_value  (raw_value),
		.vld_s1     (vld_s1),
		.data_s1    (data_s1),
		.nxt_rdy    (rdy_s1)
	);

	// Stage two: shifts.
	csei_shift u_shift (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_s1  (vld_s1),
		.rdy_s1  (rdy_s1),
		.data_s1 (data_s1),
		.vld_s2  (vld_s2),
		.data_s2 (data_s2),
		.nxt_rdy (rdy_s2)
	);

	// Stage three: merge and output register.
	csei_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.vld_s2       (vld_s2),
		.rdy_s2       (rdy_s2),
		.data_s2      (data_s2),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.signal_value (signal_value),
		.frame_out    (frame_out),
		.length_error (length_error)
	);

	// Input backpressure only appears when the output is blocked.
	`ASSERT_CLK(a_stall_only_when_full, clk, arst_n, in_stall |-> (out_valid && out_stall))
	// An accepted transaction always lands in the first stage.
	`ASSERT_CLK(a_accept_fills_s1, clk, arst_n, (in_valid && !in_stall) |=> vld_s1)
	// A length error never carries a nonzero value.
	`ASSERT_NEVER(a_err_value_zero, clk, arst_n, out_valid && length_error && (signal_value != '0))

endmodule
`default_nettype wire
